// ===== sv/cie_pkg.sv =====
// Package for the instruction execute block: op codes, widths, command and status types.
// No dependencies.
`default_nettype none
package cie_pkg;
    localparam int unsigned MemBytes = 4096;
    localparam int unsigned MemAw    = $clog2(MemBytes);
    localparam logic [3:0]  RegPc    = 4'd15;
    localparam logic [3:0]  RegLr    = 4'd14;
    localparam logic [3:0]  RegSp    = 4'd13;

    localparam logic [3:0] OpAdd = 4'h0;
    localparam logic [3:0] OpSub = 4'h1;
    localparam logic [3:0] OpMul = 4'h2;
    localparam logic [3:0] OpDiv = 4'h3;
    localparam logic [3:0] OpAnd = 4'h4;
    localparam logic [3:0] OpOr  = 4'h5;
    localparam logic [3:0] OpXor = 4'h6;
    localparam logic [3:0] OpShl = 4'h7;
    localparam logic [3:0] OpShr = 4'h8;
    localparam logic [3:0] OpMov = 4'h9;
    localparam logic [3:0] OpMvn = 4'hA;
    localparam logic [3:0] OpCmp = 4'hF;
    localparam logic [4:0] OpJmp = 5'h0B;
    localparam logic [4:0] OpCal = 5'h1B;
    localparam logic [4:0] OpBrk = 5'h1F;

    localparam logic [2:0] CcAl = 3'd0;
    localparam logic [2:0] CcNv = 3'd1;
    localparam logic [2:0] CcEq = 3'd2;
    localparam logic [2:0] CcNe = 3'd3;
    localparam logic [2:0] CcGt = 3'd4;
    localparam logic [2:0] CcGe = 3'd5;
    localparam logic [2:0] CcLt = 3'd6;

    localparam logic [1:0] CmpNone = 2'd0;
    localparam logic [1:0] CmpEq   = 2'd1;
    localparam logic [1:0] CmpGt   = 2'd2;
    localparam logic [1:0] CmpLt   = 2'd3;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        CMD_NONE  = 4'd0,
        CMD_DEC   = 4'd1,  // latch word, read operands
        CMD_EXEC  = 4'd2,  // execute and write back
        CMD_DIVI  = 4'd3,  // not issued; decode starts a divide
        CMD_DIVS  = 4'd4,  // one divide step
        CMD_DIVW  = 4'd5,  // write divide result
        CMD_MSTEP = 4'd6,  // one byte of a load or store
        CMD_MFIN  = 4'd7,  // finish load/store
        CMD_PSH   = 4'd8,  // one push/pop register step
        CMD_MULW  = 4'd9,  // write multiply result
        CMD_DONE  = 4'd10  // capture result item
    } t_cmd;

    typedef enum logic [2:0] {
        K_SIMPLE = 3'd0,
        K_DIV    = 3'd1,
        K_MEM    = 3'd2,
        K_STACK  = 3'd3,
        K_MUL    = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] nbytes;    // bytes left in a memory access
        logic       stk_more;  // push/pop has a pending register
        logic       div_last;  // divide on its last step
    } t_stat;
endpackage
`default_nettype wire

// ===== sv/cie_datapath.sv =====
// Datapath: register file, flags, data memory, shifter/ALU, serial divider, stack sequencer.
// Depends on cie_pkg.
`default_nettype none
module cie_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cie_pkg::t_cmd i_cmd,
    input  wire logic [31:0]   i_word,
    input  wire logic [3:0]    i_peek,
    output cie_pkg::t_stat     o_stat,
    output logic [31:0]        o_next_pc,
    output logic               o_halted,
    output logic               o_fault,
    output logic [31:0]        o_peek_value,
    output logic [1:0]         o_cmp,
    output logic               o_carry
);
    import cie_pkg::*;

    logic [31:0] r_rf [16];
    logic [1:0]  r_cmp;
    logic        r_c;
    logic [7:0]  r_mem [MemBytes];
    logic [7:0]  r_mrd;

    logic [31:0] r_w, r_a, r_b, r_d;
    logic        r_cond, r_halt, r_flt;
    t_kind       r_kind;
    logic [31:0] r_acc, r_addr;
    logic [2:0]  r_nb, r_bi;
    logic        r_st, r_mrdv;
    logic [31:0] r_q, r_rem;
    logic [5:0]  r_dcnt;
    logic [15:0] r_mask;
    logic [31:0] r_prod;
    logic [3:0]  r_pk;
    logic        r_pend;

    logic [4:0]  code;
    logic [3:0]  rd;
    logic [31:0] rot_imm, bsrc;
    logic        cok;
    logic [4:0]  sidx;
    logic [3:0]  preg;
    logic        pfound;

    assign code = r_w[28:24];
    assign rd   = r_w[23:20];

    // Condition check against the compare code.
    always_comb begin
        unique case (i_word[31:29])
            CcAl:    cok = 1'b1;
            CcNv:    cok = 1'b0;
            CcEq:    cok = (r_cmp == CmpEq);
            CcNe:    cok = (r_cmp == CmpGt) || (r_cmp == CmpLt);
            CcGt:    cok = (r_cmp == CmpGt);
            CcGe:    cok = (r_cmp == CmpGt) || (r_cmp == CmpEq);
            CcLt:    cok = (r_cmp == CmpLt);
            default: cok = (r_cmp == CmpLt) || (r_cmp == CmpEq);
        endcase
    end

    always_comb begin
        rot_imm = {24'd0, i_word[11:4]} << {i_word[14:12], 2'b00};
        if (i_word[15]) rot_imm = ~rot_imm;
        bsrc = i_word[0] ? rot_imm : r_rf[i_word[15:12]];
    end

    // Stack scan: push goes low to high, pop high to low.
    always_comb begin
        pfound = 1'b0;
        preg   = 4'd0;
        for (int i = 0; i < 16; i++) begin
            sidx = r_st ? 5'(i) : 5'(15 - i);
            if (!pfound && r_mask[sidx[3:0]]) begin
                pfound = 1'b1;
                preg   = sidx[3:0];
            end
        end
    end

    logic is_alu;
    always_comb begin
        is_alu    = (code[3:0] <= OpMvn) || (code == 5'(OpCmp));
        o_stat.kind     = r_kind;
        o_stat.nbytes   = r_nb;
        o_stat.stk_more = |r_mask;
        o_stat.div_last = (r_dcnt == 6'd31);
    end

    // Combinational ALU and write-back result.
    logic [31:0] res, d_new, sh_l, sh_r;
    logic        c_new, wr_rd;
    logic [1:0]  cmp_new;
    logic        big;
    always_comb begin
        big   = |r_b[31:5];
        sh_l  = big ? 32'd0 : r_a << r_b[4:0];
        sh_r  = big ? 32'd0 : r_a >> r_b[4:0];
        res   = 32'd0;
        c_new = r_c;
        wr_rd = 1'b1;
        cmp_new = r_cmp;
        if (!r_w[1]) begin
            case (code[3:0])
                OpAdd: begin res = r_a + r_b; c_new = res < r_d; end
                OpSub: begin res = r_a - r_b; c_new = res > r_d; end
                OpAnd: begin res = r_a & r_b; c_new = 1'b0; end
                OpOr:  begin res = r_a | r_b; c_new = 1'b0; end
                OpXor: begin res = r_a ^ r_b; c_new = 1'b0; end
                OpShl: begin res = sh_l; c_new = r_a[31]; end
                OpShr: begin res = sh_r; c_new = r_a[0]; end
                OpMov: begin res = r_b; c_new = 1'b0; end
                OpMvn: begin res = ~r_b; c_new = 1'b0; end
                OpCmp: begin
                    wr_rd = 1'b0;
                    res   = r_d;
                    cmp_new = (r_d == r_b) ? CmpEq : (r_d < r_b) ? CmpLt : CmpGt;
                end
                default: begin wr_rd = 1'b0; res = r_d; end
            endcase
        end else begin
            case (code[3:0])
                OpAdd: begin res = r_a + r_b + 32'(r_c); c_new = res < r_d; end
                OpSub: begin res = r_a - r_b - 32'(r_c); c_new = res > r_d; end
                OpShl: begin res = sh_r ^ {r_a[0], 31'd0}; c_new = r_a[0]; end
                default: begin res = sh_l ^ {31'd0, r_a[31]}; c_new = r_a[31]; end
            endcase
        end
        d_new = res;
        if (r_w[4]) cmp_new = (d_new == 32'd0) ? CmpEq : CmpGt;
    end

    logic [MemAw-1:0] maddr;
    logic [32:0]      dsub;
    assign maddr = MemAw'(r_addr);
    assign dsub  = {r_rem[31:0], r_q[31]} - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (r_mrdv) r_acc <= {r_mrd, r_acc[31:8]};
        r_mrdv <= 1'b0;
        if (i_cmd == CMD_MSTEP && r_st) r_mem[maddr] <= r_d[8*r_bi +: 8];
        r_mrd <= r_mem[maddr];
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) r_rf[i] <= 32'd0;
            r_cmp <= CmpNone; r_c <= 1'b0;
            r_nb <= 3'd0; r_mask <= 16'd0; r_dcnt <= 6'd0;
            o_next_pc <= 32'd0; o_halted <= 1'b0; o_fault <= 1'b0;
            o_peek_value <= 32'd0; o_cmp <= CmpNone; o_carry <= 1'b0;
            r_kind <= K_SIMPLE; r_mrdv <= 1'b0; r_pend <= 1'b0;
        end else begin
            unique case (i_cmd)
                CMD_DEC: begin
                    r_w <= i_word; r_cond <= cok; r_pk <= i_peek;
                    r_a <= r_rf[i_word[19:16]];
                    r_b <= bsrc;
                    r_d <= r_rf[i_word[23:20]];
                    r_halt <= 1'b0; r_flt <= 1'b0; r_pend <= 1'b0;
                    r_kind <= K_SIMPLE; r_nb <= 3'd0; r_mask <= 16'd0;
                    r_prod <= r_rf[i_word[19:16]] * bsrc;
                    if (cok) begin
                        if ((i_word[27:24] <= OpMvn) || (i_word[28:24] == 5'(OpCmp))) begin
                            if (i_word[1] && i_word[27:24] != OpAdd && i_word[27:24] != OpSub
                                && i_word[27:24] != OpShl && i_word[27:24] != OpShr)
                                r_flt <= 1'b1;
                            else if (!i_word[1] && i_word[27:24] == OpDiv) begin
                                r_kind <= K_DIV; r_dcnt <= 6'd0;
                                r_q <= r_rf[i_word[19:16]]; r_rem <= 32'd0;
                            end else if (!i_word[1] && i_word[27:24] == OpMul)
                                r_kind <= K_MUL;
                        end else if (i_word[28:24] == OpBrk) r_halt <= 1'b1;
                        else if (i_word[28:24] != OpJmp && i_word[28:24] != OpCal) begin
                            if (i_word[3:0] == 4'd8) begin
                                r_kind <= K_STACK; r_mask <= i_word[19:4];
                                r_st <= i_word[28];
                            end else if (i_word[0]) begin
                                if (i_word[28]) r_flt <= 1'b1;
                            end else begin
                                r_kind <= K_MEM; r_st <= i_word[28];
                                r_nb <= (i_word[25:24] == 2'd0) ? 3'd4 :
                                        (i_word[25:24] == 2'd1) ? 3'd1 : 3'd2;
                                r_bi <= 3'd0;
                                r_addr <= r_rf[i_word[19:16]] +
                                    (i_word[2] ? {24'd0, i_word[15:8]} : r_rf[i_word[15:12]]);
                                r_acc <= 32'd0;
                            end
                        end
                    end
                end
                CMD_EXEC: begin
                    if (r_cond && !r_halt && !r_flt) begin
                        if (is_alu) begin
                            if (wr_rd) r_rf[rd] <= d_new;
                            r_c <= (code[3:0] == OpCmp && !r_w[1]) ? r_c : c_new;
                            r_cmp <= cmp_new;
                            if (!(wr_rd && rd == RegPc)) r_rf[RegPc] <= r_rf[RegPc] + 32'd4;
                            else r_rf[RegPc] <= d_new + 32'd4;
                        end else if (code == OpJmp || code == OpCal) begin
                            if (code == OpCal) r_rf[RegLr] <= r_rf[RegPc];
                            if (r_w[0])
                                r_rf[RegPc] <= (|r_w[23:21]) ?
                                    r_rf[RegPc] - {8'd0, r_w[22:1], 2'b00} :
                                    r_rf[RegPc] + {8'd0, r_w[22:1], 2'b00};
                            else r_rf[RegPc] <= r_d;
                        end else begin
                            // PC-relative address load.
                            if (|r_w[19:17]) r_rf[rd] <= r_rf[RegPc] - {12'd0, r_w[18:1], 2'b00};
                            else r_rf[rd] <= r_rf[RegPc] + {12'd0, r_w[18:1], 2'b00};
                            r_rf[RegPc] <= (rd == RegPc) ?
                                ((|r_w[19:17]) ? r_rf[RegPc] - {12'd0, r_w[18:1], 2'b00} :
                                 r_rf[RegPc] + {12'd0, r_w[18:1], 2'b00}) + 32'd4 :
                                r_rf[RegPc] + 32'd4;
                        end
                    end else if (!r_cond) r_rf[RegPc] <= r_rf[RegPc] + 32'd4;
                end
                CMD_MULW: begin
                    r_rf[rd] <= r_prod; r_c <= r_prod < r_d;
                    r_cmp <= r_w[4] ? ((r_prod == 32'd0) ? CmpEq : CmpGt) : r_cmp;
                    r_rf[RegPc] <= ((rd == RegPc) ? r_prod : r_rf[RegPc]) + 32'd4;
                end
                CMD_DIVS: begin
                    // Restoring divide, one quotient bit per cycle.
                    r_dcnt <= r_dcnt + 6'd1;
                    if (!dsub[32]) begin
                        r_rem <= dsub[31:0]; r_q <= {r_q[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_q[31]}; r_q <= {r_q[30:0], 1'b0};
                    end
                end
                CMD_DIVW: begin
                    r_rf[rd] <= (r_b == 32'd0) ? 32'hFFFF_FFFF : r_q;
                    r_c <= 1'b0;
                    if (r_w[4]) r_cmp <= ((r_b != 32'd0) && r_q == 32'd0) ? CmpEq : CmpGt;
                    r_rf[RegPc] <= ((rd == RegPc) ?
                        ((r_b == 32'd0) ? 32'hFFFF_FFFF : r_q) : r_rf[RegPc]) + 32'd4;
                end
                CMD_MSTEP: begin
                    r_addr <= r_addr + 32'd1; r_bi <= r_bi + 3'd1;
                    r_nb <= r_nb - 3'd1; r_mrdv <= !r_st;
                end
                CMD_MFIN: begin
                    logic [31:0] v, nrm, base;
                    logic [3:0]  rm;
                    rm = r_w[19:16];
                    v  = (r_w[25:24] == 2'd1) ? {24'd0, r_acc[31:24]} :
                         (r_w[25:24] == 2'd0) ? r_acc : {16'd0, r_acc[31:16]};
                    // The base register steps from its value after the load.
                    base = (!r_st && rd == rm) ? v : r_rf[rm];
                    nrm = base + (r_w[1] ? {27'd0, r_w[7:3]} : r_rf[r_w[7:4]]);
                    if (!r_st) r_rf[rd] <= v;
                    r_rf[rm] <= nrm;
                    r_rf[RegPc] <= r_rf[RegPc] + 32'd4;
                    if (rm == RegPc) r_rf[RegPc] <= nrm + 32'd4;
                    else if (!r_st && rd == RegPc) r_rf[RegPc] <= v + 32'd4;
                end
                CMD_PSH: begin
                    if (pfound) begin
                        if (!r_pend) begin
                            r_addr <= r_st ? r_rf[RegSp] - 32'd4 : r_rf[RegSp];
                            // A pushed stack pointer stores its already lowered value.
                            r_d <= (r_st && preg == RegSp) ? r_rf[RegSp] - 32'd4 : r_rf[preg];
                            r_nb <= 3'd4; r_bi <= 3'd0;
                            r_acc <= 32'd0; r_pend <= 1'b1;
                            if (r_st) r_rf[RegSp] <= r_rf[RegSp] - 32'd4;
                        end else begin
                            if (!r_st) begin
                                r_rf[RegSp] <= r_rf[RegSp] + 32'd4;
                                r_rf[preg] <= (preg == RegSp) ? r_acc + 32'd4 : r_acc;
                            end
                            r_mask[preg] <= 1'b0;
                            r_pend <= 1'b0;
                        end
                    end else r_rf[RegPc] <= r_rf[RegPc] + 32'd4;
                end
                CMD_DONE: begin
                    o_next_pc <= r_rf[RegPc];
                    o_halted <= r_cond && r_halt;
                    o_fault <= r_cond && r_flt;
                    o_peek_value <= r_rf[r_pk];
                    o_cmp <= r_cmp; o_carry <= r_c;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== sv/cie_ctrl.sv =====
// Controller state machine: sequences decode, execute, divide, memory and stack steps.
// Depends on cie_pkg.
`default_nettype none
module cie_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire logic           i_out_stall,
    output logic                o_valid,
    input  wire cie_pkg::t_stat i_stat,
    output cie_pkg::t_cmd       o_cmd
);
    import cie_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001, S_DEC  = 10'b0000000010, S_EXEC = 10'b0000000100,
        S_DIV  = 10'b0000001000, S_DIVW = 10'b0000010000, S_MEM  = 10'b0000100000,
        S_MWT  = 10'b0001000000, S_STK  = 10'b0010000000, S_DONE = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_ov, n_ov;
    logic   r_pstk, n_pstk;
    logic   r_div0, n_div0;

    assign o_stall = !(r_state == S_IDLE);
    assign o_valid = r_ov;

    always_comb begin
        n_state = r_state; n_ov = r_ov; n_pstk = r_pstk; n_div0 = 1'b0;
        o_cmd = CMD_NONE;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin o_cmd = CMD_DEC; n_state = S_DEC; end
            S_DEC: begin
                unique case (i_stat.kind)
                    K_DIV:   begin o_cmd = CMD_NONE; n_state = S_DIV; end
                    K_MEM:   n_state = S_MEM;
                    K_STACK: begin n_pstk = 1'b1; n_state = S_STK; end
                    K_MUL:   begin o_cmd = CMD_MULW; n_state = S_DONE; end
                    default: begin o_cmd = CMD_EXEC; n_state = S_DONE; end
                endcase
            end
            S_DIV: begin
                o_cmd = CMD_DIVS;
                if (i_stat.div_last) n_state = S_DIVW;
            end
            S_DIVW: begin o_cmd = CMD_DIVW; n_state = S_DONE; end
            S_MEM: begin
                if (i_stat.nbytes != 3'd0) o_cmd = CMD_MSTEP;
                else begin o_cmd = CMD_NONE; n_state = S_MWT; end
            end
            S_MWT: begin
                // Reads drain through the read data register into the accumulator before the final write-back.
                if (r_pstk) begin n_pstk = 1'b0; n_state = S_STK; end
                else if (!r_div0) begin n_div0 = 1'b1; n_state = S_MWT; end
                else begin
                    o_cmd = i_stat.kind == K_STACK ? CMD_PSH : CMD_MFIN;
                    n_state = i_stat.kind == K_STACK ? S_STK : S_DONE;
                end
            end
            S_STK: begin
                o_cmd = CMD_PSH;
                if (!i_stat.stk_more) n_state = S_DONE;
                else if (i_stat.nbytes == 3'd0) n_state = S_MEM;
                n_pstk = 1'b0;
            end
            S_DONE: if (!r_ov) begin o_cmd = CMD_DONE; n_state = S_OUT; end
            S_OUT: begin n_ov = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ov <= 1'b0; r_pstk <= 1'b0; r_div0 <= 1'b0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_pstk <= n_pstk; r_div0 <= n_div0;
        end
    end
endmodule
`default_nettype wire

// ===== sv/cpu_instruction_execute.sv =====
// Top level of the instruction execute block: controller plus datapath.
// Depends on cie_pkg, cie_ctrl and cie_datapath.
//
//  channel | valid    | stall    | payload
//  input   | i_valid  | o_stall  | i_instruction_word, i_peek_index
//  output  | o_valid  | i_stall  | o_next_pc, o_halted, o_fault, o_peek_value, ...
//
// A divide runs 32 quotient steps in the serial divider, a load or store moves one byte
// at a time through the single data memory port, and a push or pop moves one register
// at a time; the block takes a new item only once it is idle again.
// Reset is synchronous and clears registers, flags and control; data memory is not cleared.
// The result waits in the output register while the next item is being accepted; a result
// still stalled there holds the next item in its final step.
`default_nettype none
module cpu_instruction_execute (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [3:0]  i_peek_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_next_pc,
    output logic             o_halted,
    output logic             o_fault,
    output logic [31:0]      o_peek_value,
    output logic [1:0]       o_compare_state,
    output logic             o_carry_flag
);
    import cie_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cie_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_out_stall(i_stall), .o_valid,
        .i_stat(stat), .o_cmd(cmd)
    );

    cie_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_word(i_instruction_word), .i_peek(i_peek_index),
        .o_stat(stat), .o_next_pc, .o_halted, .o_fault, .o_peek_value,
        .o_cmp(o_compare_state), .o_carry(o_carry_flag)
    );

    // A result never reports both a halt and a fault.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_halted && o_fault)) else $error("halt and fault together");
    // A waiting result holds while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_next_pc)) else $error("result changed");
endmodule
`default_nettype wire

// ===== dv/cie_exec_checker.sv =====
// Checker for the instruction execute block: watches both channels, predicts every result.
// Depends on cie_pkg for op codes, register indexes and the memory size.
module cie_exec_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [31:0] i_instruction_word,
    input  logic [3:0]  i_peek_index,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_next_pc,
    input  logic        i_halted,
    input  logic        i_fault,
    input  logic [31:0] i_peek_value,
    input  logic [1:0]  i_compare_state,
    input  logic        i_carry_flag,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cie_pkg::*;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        halted;
        logic        fault;
        logic [31:0] peek_value;
        logic [1:0]  compare_state;
        logic        carry_flag;
    } t_step_result;

    logic [31:0]  arch_regs [16];
    logic [1:0]   cmp_code;
    logic         carry;
    logic [7:0]   data_mem [MemBytes];
    t_step_result expected_results [$];

    function automatic logic [31:0] mem_read(input logic [31:0] a, input int n);
        logic [31:0] v;
        logic [31:0] ad;
        v = '0;
        for (int k = 0; k < n; k++) begin
            ad = a + k;
            v |= 32'(data_mem[ad % MemBytes]) << (8 * k);
        end
        return v;
    endfunction

    function automatic void mem_write(input logic [31:0] a, input logic [31:0] v, input int n);
        logic [31:0] ad;
        for (int k = 0; k < n; k++) begin
            ad = a + k;
            data_mem[ad % MemBytes] = v[8*k +: 8];
        end
    endfunction

    function automatic logic cond_pass(input logic [2:0] c);
        case (c)
            CcAl: return 1'b1;
            CcNv: return 1'b0;
            CcEq: return cmp_code == CmpEq;
            CcNe: return cmp_code == CmpGt || cmp_code == CmpLt;
            CcGt: return cmp_code == CmpGt;
            CcGe: return cmp_code == CmpGt || cmp_code == CmpEq;
            CcLt: return cmp_code == CmpLt;
            default: return cmp_code == CmpLt || cmp_code == CmpEq;
        endcase
    endfunction

    // Returns 1 when the word is an undefined extended op; nothing changes then.
    function automatic logic alu_exec(input logic [31:0] w);
        logic [3:0]  rd, sel;
        logic [31:0] rv, a, prior, r;
        logic        c;
        rd = w[23:20];
        if (w[0]) begin
            sel = w[15:12];
            rv = 32'(w[11:4]) << (sel[2:0] * 4);
            if (sel[3]) rv = ~rv;
        end else begin
            rv = arch_regs[w[15:12]];
        end
        a = arch_regs[w[19:16]];
        prior = arch_regs[rd];
        if (!w[1]) begin
            case (w[27:24])
                OpAdd: begin r = a + rv; arch_regs[rd] = r; carry = r < prior; end
                OpSub: begin r = a - rv; arch_regs[rd] = r; carry = r > prior; end
                OpMul: begin r = a * rv; arch_regs[rd] = r; carry = r < prior; end
                OpDiv: begin
                    arch_regs[rd] = (rv != 0) ? a / rv : 32'hFFFF_FFFF;
                    carry = 1'b0;
                end
                OpAnd: begin arch_regs[rd] = a & rv; carry = 1'b0; end
                OpOr:  begin arch_regs[rd] = a | rv; carry = 1'b0; end
                OpXor: begin arch_regs[rd] = a ^ rv; carry = 1'b0; end
                OpShl: begin
                    carry = a[31];
                    arch_regs[rd] = (rv >= 32) ? '0 : a << rv[4:0];
                end
                OpShr: begin
                    carry = a[0];
                    arch_regs[rd] = (rv >= 32) ? '0 : a >> rv[4:0];
                end
                OpMov: begin arch_regs[rd] = rv; carry = 1'b0; end
                OpMvn: begin arch_regs[rd] = ~rv; carry = 1'b0; end
                OpCmp: begin
                    if (prior == rv) cmp_code = CmpEq;
                    else if (prior < rv) cmp_code = CmpLt;
                    else cmp_code = CmpGt;
                end
                default: ;
            endcase
        end else begin
            case (w[27:24])
                OpAdd: begin r = a + rv + carry; arch_regs[rd] = r; carry = r < prior; end
                OpSub: begin r = a - rv - carry; arch_regs[rd] = r; carry = r > prior; end
                OpShl: begin
                    c = a[0];
                    carry = c;
                    arch_regs[rd] = ((rv >= 32) ? '0 : a >> rv[4:0]) ^ {c, 31'b0};
                end
                OpShr: begin
                    c = a[31];
                    carry = c;
                    arch_regs[rd] = ((rv >= 32) ? '0 : a << rv[4:0]) ^ {31'b0, c};
                end
                default: return 1'b1;
            endcase
        end
        if (w[4]) cmp_code = (arch_regs[rd] == 0) ? CmpEq : CmpGt;
        return 1'b0;
    endfunction

    // Loads, stores, PC-relative address and push/pop. Returns 1 on a fault.
    function automatic logic mem_exec(input logic [31:0] w);
        logic        is_store;
        int          nb;
        logic [3:0]  rd, rm;
        logic [15:0] mask;
        logic [31:0] d, off, inc, addr;
        is_store = w[28];
        nb = (w[25:24] == 2'd0) ? 4 : (w[25:24] == 2'd1) ? 1 : 2;
        rd = w[23:20];
        if (w[3:0] == 4'h8) begin
            mask = w[19:4];
            if (is_store) begin
                for (int i = 0; i < 16; i++) begin
                    if (mask[i]) begin
                        arch_regs[RegSp] -= 4;
                        mem_write(arch_regs[RegSp], arch_regs[i], 4);
                    end
                end
            end else begin
                for (int i = 15; i >= 0; i--) begin
                    if (mask[i]) begin
                        arch_regs[i] = mem_read(arch_regs[RegSp], 4);
                        arch_regs[RegSp] += 4;
                    end
                end
            end
        end else if (w[0]) begin
            if (is_store) return 1'b1;
            d = 32'(w[18:1]) << 2;
            arch_regs[rd] = (w[19:17] != 0) ? arch_regs[RegPc] - d : arch_regs[RegPc] + d;
        end else begin
            off = w[2] ? 32'(w[15:8]) : arch_regs[w[15:12]];
            inc = w[1] ? 32'(w[7:3]) : arch_regs[w[7:4]];
            rm = w[19:16];
            addr = arch_regs[rm] + off;
            if (is_store) mem_write(addr, arch_regs[rd], nb);
            else arch_regs[rd] = mem_read(addr, nb);
            arch_regs[rm] += inc;
        end
        return 1'b0;
    endfunction

    function automatic t_step_result execute_word(input logic [31:0] w, input logic [3:0] pk);
        t_step_result res;
        logic [4:0]   code;
        logic [31:0]  dst, d;
        logic         halted, fault, advance;
        code = w[28:24];
        halted = 1'b0;
        fault = 1'b0;
        advance = 1'b1;
        if (cond_pass(w[31:29])) begin
            if (code[3:0] <= OpMvn || code == {1'b0, OpCmp}) begin
                fault = alu_exec(w);
            end else if (code == OpJmp || code == OpCal) begin
                if (w[0]) begin
                    d = 32'(w[22:1]) << 2;
                    dst = (w[23:21] != 0) ? arch_regs[RegPc] - d : arch_regs[RegPc] + d;
                end else begin
                    dst = arch_regs[w[23:20]];
                end
                if (code == OpCal) arch_regs[RegLr] = arch_regs[RegPc];
                arch_regs[RegPc] = dst;
                advance = 1'b0;
            end else if (code == OpBrk) begin
                halted = 1'b1;
            end else begin
                fault = mem_exec(w);
            end
            if (halted || fault) advance = 1'b0;
        end
        if (advance) arch_regs[RegPc] += 4;
        res.next_pc = arch_regs[RegPc];
        res.halted = halted;
        res.fault = fault;
        res.peek_value = arch_regs[pk];
        res.compare_state = cmp_code;
        res.carry_flag = carry;
        return res;
    endfunction

    initial begin
        o_errors = 0;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (data_mem[i]) data_mem[i] = '0;
        cmp_code = CmpNone;
        carry = 1'b0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_step_result exp_res;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in)
                expected_results.push_back(execute_word(i_instruction_word, i_peek_index));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result with no item pending");
                    o_errors++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (i_next_pc !== exp_res.next_pc) begin
                        $error("next_pc: expected %h, got %h", exp_res.next_pc, i_next_pc);
                        o_errors++;
                    end
                    if (i_halted !== exp_res.halted) begin
                        $error("halted: expected %b, got %b", exp_res.halted, i_halted);
                        o_errors++;
                    end
                    if (i_fault !== exp_res.fault) begin
                        $error("fault: expected %b, got %b", exp_res.fault, i_fault);
                        o_errors++;
                    end
                    if (i_peek_value !== exp_res.peek_value) begin
                        $error("peek_value: expected %h, got %h",
                               exp_res.peek_value, i_peek_value);
                        o_errors++;
                    end
                    if (i_compare_state !== exp_res.compare_state) begin
                        $error("compare_state: expected %0d, got %0d",
                               exp_res.compare_state, i_compare_state);
                        o_errors++;
                    end
                    if (i_carry_flag !== exp_res.carry_flag) begin
                        $error("carry_flag: expected %b, got %b",
                               exp_res.carry_flag, i_carry_flag);
                        o_errors++;
                    end
                end
            end
        end
    end
endmodule

// ===== dv/tb_cpu_instruction_execute.sv =====
// Testbench top for the instruction execute block: clock, reset, item stimulus and verdict.
// Depends on cie_pkg, cpu_instruction_execute and the cie_exec_checker module.
module tb_cpu_instruction_execute;
    timeunit 1ns;
    timeprecision 1ps;
    import cie_pkg::*;

    localparam int FillItems   = MemBytes / 64;
    localparam int RandomItems = 1307;

    logic        i_clk, i_rst_n;
    logic        i_valid, o_stall;
    logic [31:0] i_instruction_word;
    logic [3:0]  i_peek_index;
    logic        o_valid, i_stall;
    logic [31:0] o_next_pc, o_peek_value;
    logic        o_halted, o_fault, o_carry_flag;
    logic [1:0]  o_compare_state;
    int          errors, pending;
    logic        quiet;

    cpu_instruction_execute dut (.*);

    cie_exec_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_instruction_word, .i_peek_index,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_next_pc(o_next_pc), .i_halted(o_halted), .i_fault(o_fault),
        .i_peek_value(o_peek_value), .i_compare_state(o_compare_state),
        .i_carry_flag(o_carry_flag), .o_errors(errors), .o_pending(pending)
    );

    // Directed words: plain ALU ops but AND, OR and XOR, extended add, subtract and shifts,
    // rotated immediates, division by zero, compare with zero, conditions but GT and GE,
    // jumps and calls both ways, PC-relative address, the store-immediate fault, full push
    // and pop, byte and halfword accesses, and a break that runs and one that is skipped.
    logic [31:0] directed_words [] = '{
        32'h0920_7FF1, 32'h0A30_8AB1, 32'h0043_2010, 32'h0153_2000, 32'h0254_2000,
        32'h0355_0001, 32'h0362_3000, 32'h0772_3000, 32'h0872_0041, 32'h0042_3002,
        32'h0142_3002, 32'h0782_0012, 32'h0882_0013, 32'h0442_0002, 32'h0F02_3000,
        32'h4990_0011, 32'h6990_0021, 32'hC990_0031, 32'hE990_0041, 32'h0BE0_0021,
        32'h1B20_0000, 32'h0CA0_0101, 32'h1CA0_0101, 32'h1C0F_FFF8, 32'h0C0F_FFF8,
        32'h1E20_0306, 32'h0D30_0306, 32'h1F00_0000, 32'h3F00_0000
    };

    // Random word: mostly unconditional so that ops really run, with the
    // condition field and the op code drawn across their whole range.
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        w = $urandom();
        if ($urandom_range(0, 9) < 6) w[31:29] = CcAl;
        if ($urandom_range(0, 9) == 0) w[28:24] = OpBrk;
        return w;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: a random stall, possibly none, before every result, with quiet stretches.
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 12);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid || i_stall);
        end
    end

    initial begin
        int gap;
        int total;
        logic [31:0] w;
        i_valid = 1'b0;
        i_instruction_word = '0;
        i_peek_index = '0;
        i_rst_n = 1'b0;
        quiet = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first items push all sixteen registers, 64 bytes each, walking the
        // stack pointer down once around the whole data memory, so no later load
        // or pop can touch a byte that was never written.
        total = FillItems + directed_words.size() + RandomItems;
        for (int idx = 0; idx < total; idx++) begin
            if (idx % 200 == 0) quiet = ($urandom_range(0, 3) == 0);
            if (idx < FillItems) w = 32'h1C0F_FFF8;
            else if (idx < FillItems + directed_words.size())
                w = directed_words[idx - FillItems];
            else w = random_word();
            gap = quiet ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_instruction_word <= w;
            i_peek_index <= 4'($urandom_range(0, 15));
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/cie_pkg.sv
sv/cie_datapath.sv
sv/cie_ctrl.sv
sv/cpu_instruction_execute.sv
dv/cie_exec_checker.sv
dv/tb_cpu_instruction_execute.sv
